// ===== rtl/rv32_instruction_decoder_assert.svh =====
// Assertion macros for the instruction decoder checker.
`ifndef RV32_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32_INSTRUCTION_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RVID_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: decoder check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RVID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: decoder check failed");

`endif

// ===== rtl/rvid_pkg.sv =====
`timescale 1ns / 1ps

package rvid_pkg;

  localparam logic [6:0] OPC_OP       = 7'd51;
  localparam logic [6:0] OPC_OPIMM    = 7'd19;
  localparam logic [6:0] OPC_OPFP     = 7'd83;
  localparam logic [6:0] OPC_LUI      = 7'd55;
  localparam logic [6:0] OPC_AUIPC    = 7'd23;
  localparam logic [6:0] OPC_JAL      = 7'd111;
  localparam logic [6:0] OPC_JALR     = 7'd103;
  localparam logic [6:0] OPC_LOAD     = 7'd3;
  localparam logic [6:0] OPC_STORE    = 7'd35;
  localparam logic [6:0] OPC_LOADFP   = 7'd7;
  localparam logic [6:0] OPC_STOREFP  = 7'd39;
  localparam logic [6:0] OPC_BRANCH   = 7'd99;
  localparam logic [6:0] OPC_MADD     = 7'd67;
  localparam logic [6:0] OPC_MSUB     = 7'd71;
  localparam logic [6:0] OPC_NMSUB    = 7'd75;
  localparam logic [6:0] OPC_NMADD    = 7'd79;

  localparam logic [6:0] ID_NONE  = 7'd0;
  localparam logic [6:0] ID_LUI   = 7'd91;
  localparam logic [6:0] ID_AUIPC = 7'd92;
  localparam logic [6:0] ID_JAL   = 7'd93;
  localparam logic [6:0] ID_JALR  = 7'd94;
  localparam logic [6:0] ID_FMA_BASE = 7'd83;

  typedef enum logic [3:0] {
    CLS_OP      = 4'd0,
    CLS_OPIMM   = 4'd1,
    CLS_OPFP    = 4'd2,
    CLS_LUI     = 4'd3,
    CLS_AUIPC   = 4'd4,
    CLS_JAL     = 4'd5,
    CLS_JALR    = 4'd6,
    CLS_LOAD    = 4'd7,
    CLS_STORE   = 4'd8,
    CLS_LOADFP  = 4'd9,
    CLS_STOREFP = 4'd10,
    CLS_BRANCH  = 4'd11,
    CLS_FMA     = 4'd12,
    CLS_OTHER   = 4'd13
  } class_e;

  typedef enum logic [2:0] {
    FMT_R    = 3'd0,
    FMT_R4   = 3'd1,
    FMT_I    = 3'd2,
    FMT_S    = 3'd3,
    FMT_B    = 3'd4,
    FMT_U    = 3'd5,
    FMT_J    = 3'd6,
    FMT_NONE = 3'd7
  } fmt_e;

  typedef struct packed {
    logic       hit;
    logic [6:0] id;
  } op_match_t;

  typedef struct packed {
    logic               recognized;
    class_e             major_class;
    fmt_e               format_kind;
    logic [6:0]         op_id;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [4:0]         src3_reg;
    logic [2:0]         function3;
    logic signed [31:0] immediate;
    logic [31:0]        target_addr;
  } dec_t;

endpackage

// ===== rtl/rvid_op_lookup.sv =====
`timescale 1ns / 1ps

module rvid_op_lookup (
  input  logic [31:0]          word_i,
  input  rvid_pkg::class_e     cls_i,
  output rvid_pkg::op_match_t  match_o
);
  import rvid_pkg::*;

  logic [2:0] f3;
  logic [6:0] f7;
  logic [1:0] f2;
  logic [4:0] rs2;
  logic [6:0] base_id;
  logic [6:0] int_id;
  logic [6:0] fp_id;
  logic [1:0] grp;

  assign f3  = word_i[14:12];
  assign f7  = word_i[31:25];
  assign f2  = word_i[26:25];
  assign rs2 = word_i[24:20];

  always_comb begin
    int_id = ID_NONE;
    case (f7)
      7'd0: begin
        case (f3)
          3'd0: int_id = 7'd1;
          3'd1: int_id = 7'd3;
          3'd2: int_id = 7'd4;
          3'd3: int_id = 7'd5;
          3'd4: int_id = 7'd6;
          3'd5: int_id = 7'd7;
          3'd6: int_id = 7'd9;
          3'd7: int_id = 7'd10;
          default: int_id = ID_NONE;
        endcase
      end
      7'd32: begin
        case (f3)
          3'd0: int_id = 7'd2;
          3'd5: int_id = 7'd8;
          default: int_id = ID_NONE;
        endcase
      end
      7'd1: int_id = 7'd11 + {4'd0, f3};
      default: int_id = ID_NONE;
    endcase
  end

  always_comb begin
    fp_id = ID_NONE;
    case (f7)
      7'd0:  fp_id = 7'd33;
      7'd4:  fp_id = 7'd34;
      7'd8:  fp_id = 7'd35;
      7'd12: fp_id = 7'd36;
      7'd1:  fp_id = 7'd37;
      7'd5:  fp_id = 7'd38;
      7'd9:  fp_id = 7'd39;
      7'd13: fp_id = 7'd40;
      7'd16: if (f3 <= 3'd2) fp_id = 7'd41 + {4'd0, f3};
      7'd17: if (f3 <= 3'd2) fp_id = 7'd44 + {4'd0, f3};
      7'd20: if (f3 <= 3'd1) fp_id = 7'd47 + {4'd0, f3};
      7'd21: if (f3 <= 3'd1) fp_id = 7'd49 + {4'd0, f3};
      7'd80: if (f3 <= 3'd2) fp_id = 7'd51 + {4'd0, f3};
      7'd81: if (f3 <= 3'd2) fp_id = 7'd54 + {4'd0, f3};
      7'd44: if (rs2 == 5'd0) fp_id = 7'd57;
      7'd45: if (rs2 == 5'd0) fp_id = 7'd58;
      7'd96: if (rs2 <= 5'd1) fp_id = 7'd59 + {6'd0, rs2[0]};
      7'd104: if (rs2 <= 5'd1) fp_id = 7'd61 + {6'd0, rs2[0]};
      7'd32: if (rs2 == 5'd1) fp_id = 7'd63;
      7'd33: if (rs2 == 5'd0) fp_id = 7'd64;
      7'd97: if (rs2 <= 5'd1) fp_id = 7'd65 + {6'd0, rs2[0]};
      7'd105: if (rs2 <= 5'd1) fp_id = 7'd67 + {6'd0, rs2[0]};
      7'd112: begin
        if (rs2 == 5'd0 && f3 == 3'd0) fp_id = 7'd69;
        if (rs2 == 5'd0 && f3 == 3'd1) fp_id = 7'd71;
      end
      7'd120: if (rs2 == 5'd0 && f3 == 3'd0) fp_id = 7'd70;
      7'd113: if (rs2 == 5'd0 && f3 == 3'd1) fp_id = 7'd72;
      default: fp_id = ID_NONE;
    endcase
  end

  always_comb begin
    case (word_i[6:0])
      OPC_MADD:  grp = 2'd0;
      OPC_NMADD: grp = 2'd1;
      OPC_MSUB:  grp = 2'd2;
      default:   grp = 2'd3;
    endcase
  end

  always_comb begin
    base_id = ID_NONE;
    case (cls_i)
      CLS_OP:    base_id = int_id;
      CLS_OPFP:  base_id = fp_id;
      CLS_OPIMM: begin
        case (f3)
          3'd0: base_id = 7'd19;
          3'd2: base_id = 7'd20;
          3'd3: base_id = 7'd21;
          3'd4: base_id = 7'd22;
          3'd6: base_id = 7'd23;
          3'd7: base_id = 7'd24;
          default: base_id = ID_NONE;
        endcase
      end
      CLS_LOAD: begin
        case (f3)
          3'd0: base_id = 7'd25;
          3'd1: base_id = 7'd26;
          3'd2: base_id = 7'd27;
          3'd4: base_id = 7'd28;
          3'd5: base_id = 7'd29;
          default: base_id = ID_NONE;
        endcase
      end
      CLS_STORE: if (f3 <= 3'd2) base_id = 7'd30 + {4'd0, f3};
      CLS_LOADFP: begin
        if (f3 == 3'd2) base_id = 7'd73;
        if (f3 == 3'd3) base_id = 7'd74;
      end
      CLS_STOREFP: begin
        if (f3 == 3'd2) base_id = 7'd75;
        if (f3 == 3'd3) base_id = 7'd76;
      end
      CLS_BRANCH: begin
        case (f3)
          3'd0: base_id = 7'd77;
          3'd1: base_id = 7'd78;
          3'd4: base_id = 7'd79;
          3'd5: base_id = 7'd80;
          3'd6: base_id = 7'd81;
          3'd7: base_id = 7'd82;
          default: base_id = ID_NONE;
        endcase
      end
      CLS_FMA:   if (!f2[1]) base_id = ID_FMA_BASE + {4'd0, grp, f2[0]};
      CLS_LUI:   base_id = ID_LUI;
      CLS_AUIPC: base_id = ID_AUIPC;
      CLS_JAL:   base_id = ID_JAL;
      CLS_JALR:  base_id = ID_JALR;
      default:   base_id = ID_NONE;
    endcase
  end

  assign match_o.id  = base_id;
  assign match_o.hit = (base_id != ID_NONE);

endmodule

// ===== rtl/rvid_decode.sv =====
`timescale 1ns / 1ps

module rvid_decode (
  input  logic [31:0]     word_i,
  input  logic [31:0]     addr_i,
  output rvid_pkg::dec_t  dec_o
);
  import rvid_pkg::*;

  class_e     cls;
  fmt_e       fmt;
  op_match_t  match;
  logic       sgn;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] imm;
  logic [31:0] tgt_sum;

  assign sgn   = word_i[31];
  assign imm_i = {{21{sgn}}, word_i[30:20]};
  assign imm_s = {{21{sgn}}, word_i[30:25], word_i[11:7]};
  assign imm_b = {{20{sgn}}, word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign imm_u = {word_i[31:12], 12'd0};
  assign imm_j = {{12{sgn}}, word_i[19:12], word_i[20], word_i[30:21], 1'b0};

  always_comb begin
    case (word_i[6:0])
      OPC_OP:      begin cls = CLS_OP;      fmt = FMT_R;    end
      OPC_OPIMM:   begin cls = CLS_OPIMM;   fmt = FMT_I;    end
      OPC_OPFP:    begin cls = CLS_OPFP;    fmt = FMT_R;    end
      OPC_LUI:     begin cls = CLS_LUI;     fmt = FMT_U;    end
      OPC_AUIPC:   begin cls = CLS_AUIPC;   fmt = FMT_U;    end
      OPC_JAL:     begin cls = CLS_JAL;     fmt = FMT_J;    end
      OPC_JALR:    begin cls = CLS_JALR;    fmt = FMT_I;    end
      OPC_LOAD:    begin cls = CLS_LOAD;    fmt = FMT_I;    end
      OPC_STORE:   begin cls = CLS_STORE;   fmt = FMT_S;    end
      OPC_LOADFP:  begin cls = CLS_LOADFP;  fmt = FMT_I;    end
      OPC_STOREFP: begin cls = CLS_STOREFP; fmt = FMT_S;    end
      OPC_BRANCH:  begin cls = CLS_BRANCH;  fmt = FMT_B;    end
      OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
        cls = CLS_FMA;
        fmt = FMT_R4;
      end
      default:     begin cls = CLS_OTHER;   fmt = FMT_NONE; end
    endcase
  end

  rvid_op_lookup u_lookup (
    .word_i  (word_i),
    .cls_i   (cls),
    .match_o (match)
  );

  always_comb begin
    case (fmt)
      FMT_I:   imm = imm_i;
      FMT_S:   imm = imm_s;
      FMT_B:   imm = imm_b;
      FMT_U:   imm = imm_u;
      FMT_J:   imm = imm_j;
      default: imm = 32'd0;
    endcase
  end

  assign tgt_sum = addr_i + imm;

  always_comb begin
    dec_o.recognized  = (cls == CLS_OTHER) ? 1'b0 :
                        (cls == CLS_OPFP) ? match.hit : 1'b1;
    dec_o.major_class = cls;
    dec_o.format_kind = fmt;
    dec_o.op_id       = match.id;
    dec_o.dest_reg    = 5'd0;
    dec_o.src1_reg    = 5'd0;
    dec_o.src2_reg    = 5'd0;
    dec_o.src3_reg    = 5'd0;
    dec_o.function3   = 3'd0;
    dec_o.immediate   = $signed(imm);
    dec_o.target_addr = 32'd0;
    case (fmt)
      FMT_R, FMT_R4: begin
        dec_o.dest_reg  = word_i[11:7];
        dec_o.src1_reg  = word_i[19:15];
        dec_o.src2_reg  = word_i[24:20];
        dec_o.function3 = word_i[14:12];
        if (fmt == FMT_R4) dec_o.src3_reg = word_i[31:27];
      end
      FMT_I: begin
        dec_o.dest_reg  = word_i[11:7];
        dec_o.src1_reg  = word_i[19:15];
        dec_o.function3 = word_i[14:12];
      end
      FMT_S, FMT_B: begin
        dec_o.src1_reg  = word_i[19:15];
        dec_o.src2_reg  = word_i[24:20];
        dec_o.function3 = word_i[14:12];
        if (fmt == FMT_B) dec_o.target_addr = tgt_sum;
      end
      FMT_U: dec_o.dest_reg = word_i[11:7];
      FMT_J: begin
        dec_o.dest_reg    = word_i[11:7];
        dec_o.target_addr = tgt_sum;
      end
      default: dec_o.major_class = CLS_OTHER;
    endcase
  end

endmodule

// ===== rtl/rv32_instruction_decoder.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// command   | start_i, busy_o     | instr_word_i, instr_addr_i
// result    | done_o (one cycle)  | recognized_o .. target_addr_o
//
// One beat is accepted every cycle; busy_o stays low.
// A result appears on done_o once its command has passed through the
// input register and then the result register.
// Reset clears both valid flags; no result is shown until a new beat arrives.
// The receiver cannot stall, so nothing is held back.

module rv32_instruction_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [31:0]        instr_word_i,
  input  logic [31:0]        instr_addr_i,
  output logic               done_o,
  output logic               recognized_o,
  output logic [3:0]         major_class_o,
  output logic [2:0]         format_kind_o,
  output logic [6:0]         op_id_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic [4:0]         src3_reg_o,
  output logic [2:0]         function3_o,
  output logic signed [31:0] immediate_o,
  output logic [31:0]        target_addr_o
);
  import rvid_pkg::*;

  logic        in_valid_q;
  logic [31:0] word_q;
  logic [31:0] addr_q;
  logic        out_valid_q;
  dec_t        dec_d;
  dec_t        res_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start_i && !busy_o;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      word_q <= instr_word_i;
      addr_q <= instr_addr_i;
    end
    if (in_valid_q) begin
      res_q <= dec_d;
    end
  end

  rvid_decode u_decode (
    .word_i (word_q),
    .addr_i (addr_q),
    .dec_o  (dec_d)
  );

  assign done_o        = out_valid_q;
  assign recognized_o  = res_q.recognized;
  assign major_class_o = res_q.major_class;
  assign format_kind_o = res_q.format_kind;
  assign op_id_o       = res_q.op_id;
  assign dest_reg_o    = res_q.dest_reg;
  assign src1_reg_o    = res_q.src1_reg;
  assign src2_reg_o    = res_q.src2_reg;
  assign src3_reg_o    = res_q.src3_reg;
  assign function3_o   = res_q.function3;
  assign immediate_o   = res_q.immediate;
  assign target_addr_o = res_q.target_addr;

endmodule

// ===== rtl/rvid_checker.sv =====
`timescale 1ns / 1ps

`include "rv32_instruction_decoder_assert.svh"

module rvid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [31:0]        instr_addr_i,
  input logic               done_o,
  input logic               recognized_o,
  input logic [3:0]         major_class_o,
  input logic [2:0]         format_kind_o,
  input logic [6:0]         op_id_o,
  input logic [4:0]         src3_reg_o,
  input logic signed [31:0] immediate_o,
  input logic [31:0]        target_addr_o
);
  import rvid_pkg::*;

  `RVID_ASSERT(a_done_follows_start, done_o, $past(start_i && !busy_o, 2))
  `RVID_ASSERT(a_unknown_blank, done_o && !recognized_o && major_class_o != CLS_OPFP, format_kind_o == FMT_NONE && op_id_o == ID_NONE && immediate_o == 32'sd0)
  `RVID_ASSERT(a_target_only_b_j, done_o && format_kind_o != FMT_B && format_kind_o != FMT_J, target_addr_o == 32'd0)
  `RVID_ASSERT(a_branch_target, done_o && format_kind_o == FMT_B, target_addr_o == 32'($past(instr_addr_i, 2) + $unsigned(immediate_o)))
  `RVID_ASSERT(a_rs3_only_r4, done_o && format_kind_o != FMT_R4, src3_reg_o == 5'd0)

endmodule

bind rv32_instruction_decoder rvid_checker u_rvid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .instr_addr_i  (instr_addr_i),
  .done_o        (done_o),
  .recognized_o  (recognized_o),
  .major_class_o (major_class_o),
  .format_kind_o (format_kind_o),
  .op_id_o       (op_id_o),
  .src3_reg_o    (src3_reg_o),
  .immediate_o   (immediate_o),
  .target_addr_o (target_addr_o)
);
